// ===== design/mrer_pkg.sv =====
// Shared types and constants for the multi-reader event ring.
// No dependencies; imported by the front, back and top-level modules.
package mrer_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_CHECK  = 2'd1;
  localparam logic [1:0] FUNC_BATCH  = 2'd2;
  localparam logic [1:0] FUNC_POINTS = 2'd3;

  // Result kind codes
  localparam logic [1:0] KIND_EVENT   = 2'd0;
  localparam logic [1:0] KIND_POINT   = 2'd1;
  localparam logic [1:0] KIND_PENDING = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  localparam logic [15:0] CFG_BASE_RESET = 16'd1;
  localparam int unsigned MAX_POINT_RUN  = 32;

  // Ring entry: address, value, time tag
  localparam int unsigned TS_W = 56;
  localparam int unsigned EV_W = 16 + 8 + TS_W;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_CHECK,
    OP_BATCH,
    OP_POINTS,
    OP_REJECT
  } op_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    op_t              op;
    logic [1:0]       reader;
    logic [15:0]      info_addr;
    logic [7:0]       point_value;
    logic [TS_W-1:0]  timestamp;
    logic [5:0]       count;
    logic             in_window;
    logic [15:0]      offset;
  } cmd_t;

endpackage

// ===== design/multi_reader_event_ring_unit.sv =====
// Multi-reader event ring: top level with the status base register.
// Flow: a write lands in the ring once the back end takes it from the queue; a check or
// rejected request shows its result in the result register. Batch and status reads do a
// registered ring or status read for each result, then show that result from it.
// Reset: synchronous active low; afterwards a clearing pass zeroes the status table,
// during which in_stall is high. Configuration writes are taken at once.
module multi_reader_event_ring_unit import mrer_pkg::*; #(
  parameter int EVENT_DEPTH = 64,
  parameter int READERS     = 4,
  parameter int BATCH       = 8,
  parameter int POINTS      = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_reader,
  input  logic [15:0] in_info_addr,
  input  logic [7:0]  in_point_value,
  input  logic [55:0] in_timestamp,
  input  logic [5:0]  in_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_info_addr_res,
  output logic [7:0]  out_point_value_res,
  output logic [55:0] out_timestamp_res,
  output logic        out_pending,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_status_base_addr
);

  logic [15:0] base_r, base_nxt;
  logic        q_valid;
  cmd_t        q_cmd;
  logic        q_take;
  logic        clearing;

  assign cfg_ready = 1'b1;
  assign base_nxt  = (cfg_valid && cfg_ready) ? cfg_status_base_addr : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= CFG_BASE_RESET;
    end else begin
      base_r <= base_nxt;
    end
  end

  mrer_front #(
    .READERS (READERS),
    .POINTS  (POINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_reader      (in_reader),
    .in_info_addr   (in_info_addr),
    .in_point_value (in_point_value),
    .in_timestamp   (in_timestamp),
    .in_count       (in_count),
    .status_base    (base_r),
    .clearing       (clearing),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_take         (q_take)
  );

  mrer_back #(
    .EVENT_DEPTH (EVENT_DEPTH),
    .READERS     (READERS),
    .BATCH       (BATCH),
    .POINTS      (POINTS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_cmd               (q_cmd),
    .q_take              (q_take),
    .clearing            (clearing),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_info_addr_res   (out_info_addr_res),
    .out_point_value_res (out_point_value_res),
    .out_timestamp_res   (out_timestamp_res),
    .out_pending         (out_pending),
    .out_last            (out_last)
  );

  // No transaction enters while the status table is being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !clearing)
    else $error("input accepted during status clear");

  a_no_result_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid)
    else $error("result shown during status clear");

  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_REJECT) |-> (out_last && out_timestamp_res == 56'd0))
    else $error("rejected result malformed");

  a_pending_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_PENDING) |-> !out_pending)
    else $error("pending flag on non-check result");

endmodule

// ===== design/mrer_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
// Depends on mrer_pkg for the command type and the code constants.
module mrer_front import mrer_pkg::*; #(
  parameter int READERS = 4,
  parameter int POINTS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_reader,
  input  logic [15:0] in_info_addr,
  input  logic [7:0]  in_point_value,
  input  logic [55:0] in_timestamp,
  input  logic [5:0]  in_count,
  input  logic [15:0] status_base,
  input  logic        clearing,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_take
);

  localparam int QD = 2;

  cmd_t       q_r [QD];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  cmd_t        cls;
  logic        push;
  logic        above_base;
  logic        reader_ok;
  logic        run_ok;
  logic [15:0] diff;
  logic [17:0] run_end;
  logic [17:0] win_end;

  always_comb begin
    diff       = in_info_addr - status_base;
    above_base = in_info_addr >= status_base;
    reader_ok  = 32'(in_reader) < READERS;
    run_end    = 18'(in_info_addr) + 18'(in_count);
    win_end    = 18'(status_base) + 18'(POINTS);
    run_ok     = (in_count != 6'd0) && (32'(in_count) <= MAX_POINT_RUN) && above_base &&
                 (run_end <= win_end);

    cls.reader      = in_reader;
    cls.info_addr   = in_info_addr;
    cls.point_value = in_point_value;
    cls.timestamp   = in_timestamp;
    cls.count       = in_count;
    cls.offset      = diff;
    cls.in_window   = above_base && (32'(diff) < POINTS);
    case (in_func)
      FUNC_WRITE:  cls.op = OP_WRITE;
      FUNC_CHECK:  cls.op = reader_ok ? OP_CHECK : OP_REJECT;
      FUNC_BATCH:  cls.op = reader_ok ? OP_BATCH : OP_REJECT;
      FUNC_POINTS: cls.op = run_ok ? OP_POINTS : OP_REJECT;
      default:     cls.op = OP_REJECT;
    endcase
  end

  // Hold off new transactions while the queue is full or the status table is clearing
  assign in_stall = (cnt_r == 2'(QD)) || clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign q_cmd    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_take ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== design/mrer_back.sv =====
// Back end: event ring, reader slots, status table and the result register.
// Depends on mrer_pkg; takes classified commands from mrer_front.
module mrer_back import mrer_pkg::*; #(
  parameter int EVENT_DEPTH = 64,
  parameter int READERS     = 4,
  parameter int BATCH       = 8,
  parameter int POINTS      = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_take,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_info_addr_res,
  output logic [7:0]  out_point_value_res,
  output logic [55:0] out_timestamp_res,
  output logic        out_pending,
  output logic        out_last
);

  localparam int SLOT_W = $clog2(EVENT_DEPTH);
  localparam int RD_W   = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int PT_W   = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int BN_W   = $clog2(BATCH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(EVENT_DEPTH - 1);
  localparam logic [PT_W-1:0]   LAST_PT   = PT_W'(POINTS - 1);
  localparam logic [BN_W-1:0]   LAST_BN   = BN_W'(BATCH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BAT_RD,
    S_BAT_OUT,
    S_PT_RD,
    S_PT_OUT
  } state_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  // Memories
  logic [EV_W-1:0] ring_mem [EVENT_DEPTH];
  logic [7:0]      stat_mem [POINTS];
  logic [EV_W-1:0] ring_q;
  logic [7:0]      stat_q;
  logic              ring_we, ring_re;
  logic [SLOT_W-1:0] ring_wa, ring_ra;
  logic [EV_W-1:0]   ring_wd;
  logic              stat_we, stat_re;
  logic [PT_W-1:0]   stat_wa, stat_ra;
  logic [7:0]        stat_wd;

  // Control state
  state_t            state_r, state_nxt;
  logic [PT_W-1:0]   clr_r, clr_nxt;
  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [SLOT_W-1:0] rs_r [READERS];
  logic [SLOT_W-1:0] rs_nxt [READERS];
  logic [RD_W-1:0]   cur_rd_r, cur_rd_nxt;
  logic [BN_W-1:0]   bn_r, bn_nxt;
  logic              blast_r, blast_nxt;
  logic [15:0]       cur_addr_r, cur_addr_nxt;
  logic [PT_W-1:0]   cur_idx_r, cur_idx_nxt;
  logic [5:0]        left_r, left_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Result payload
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  val_r, val_nxt;
  logic [55:0] ts_r, ts_nxt;
  logic        pend_r, pend_nxt;
  logic        last_r, last_nxt;

  logic              out_free;
  logic [RD_W-1:0]   rd_sel;
  logic [SLOT_W-1:0] q_rs;
  logic [SLOT_W-1:0] ws_new;
  logic [SLOT_W-1:0] bat_slot;
  logic [SLOT_W-1:0] bat_next;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    if (ring_re) begin
      ring_q <= ring_mem[ring_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[stat_wa] <= stat_wd;
    end
    if (stat_re) begin
      stat_q <= stat_mem[stat_ra];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign rd_sel   = RD_W'(q_cmd.reader);
  assign q_rs     = rs_r[rd_sel];
  assign ws_new   = next_slot(ws_r);
  assign bat_slot = rs_r[cur_rd_r];
  assign bat_next = next_slot(bat_slot);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ws_nxt        = ws_r;
    rs_nxt        = rs_r;
    cur_rd_nxt    = cur_rd_r;
    bn_nxt        = bn_r;
    blast_nxt     = blast_r;
    cur_addr_nxt  = cur_addr_r;
    cur_idx_nxt   = cur_idx_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    val_nxt       = val_r;
    ts_nxt        = ts_r;
    pend_nxt      = pend_r;
    last_nxt      = last_r;
    q_take        = 1'b0;
    ring_we       = 1'b0;
    ring_wa       = ws_r;
    ring_wd       = {q_cmd.info_addr, q_cmd.point_value, q_cmd.timestamp};
    ring_re       = 1'b0;
    ring_ra       = bat_slot;
    stat_we       = 1'b0;
    stat_wa       = PT_W'(q_cmd.offset);
    stat_wd       = q_cmd.point_value;
    stat_re       = 1'b0;
    stat_ra       = cur_idx_r;

    case (state_r)
      S_CLEAR: begin
        stat_we = 1'b1;
        stat_wa = clr_r;
        stat_wd = 8'd0;
        if (clr_r == LAST_PT) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_WRITE: begin
              q_take  = 1'b1;
              ring_we = 1'b1;
              stat_we = q_cmd.in_window;
              ws_nxt  = ws_new;
              // push any reader the writer has caught up with
              for (int i = 0; i < READERS; i++) begin
                if (rs_r[i] == ws_new) begin
                  rs_nxt[i] = next_slot(rs_r[i]);
                end
              end
            end
            OP_CHECK: begin
              if (out_free) begin
                q_take        = 1'b1;
                out_valid_nxt = 1'b1;
                kind_nxt      = KIND_PENDING;
                addr_nxt      = 16'd0;
                val_nxt       = 8'd0;
                ts_nxt        = 56'd0;
                pend_nxt      = q_rs != ws_r;
                last_nxt      = 1'b1;
              end
            end
            OP_BATCH: begin
              if (q_rs != ws_r) begin
                q_take     = 1'b1;
                cur_rd_nxt = rd_sel;
                bn_nxt     = '0;
                state_nxt  = S_BAT_RD;
              end else if (out_free) begin
                q_take        = 1'b1;
                out_valid_nxt = 1'b1;
                kind_nxt      = KIND_REJECT;
                addr_nxt      = 16'd0;
                val_nxt       = 8'd0;
                ts_nxt        = 56'd0;
                pend_nxt      = 1'b0;
                last_nxt      = 1'b1;
              end
            end
            OP_POINTS: begin
              q_take       = 1'b1;
              cur_addr_nxt = q_cmd.info_addr;
              cur_idx_nxt  = PT_W'(q_cmd.offset);
              left_nxt     = q_cmd.count;
              state_nxt    = S_PT_RD;
            end
            default: begin
              if (out_free) begin
                q_take        = 1'b1;
                out_valid_nxt = 1'b1;
                kind_nxt      = KIND_REJECT;
                addr_nxt      = 16'd0;
                val_nxt       = 8'd0;
                ts_nxt        = 56'd0;
                pend_nxt      = 1'b0;
                last_nxt      = 1'b1;
              end
            end
          endcase
        end
      end

      S_BAT_RD: begin
        // fetch one entry and advance the reader past it
        ring_re          = 1'b1;
        rs_nxt[cur_rd_r] = bat_next;
        bn_nxt           = bn_r + 1'b1;
        blast_nxt        = (bn_r == LAST_BN) || (bat_next == ws_r);
        state_nxt        = S_BAT_OUT;
      end

      S_BAT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_EVENT;
          addr_nxt      = ring_q[EV_W-1 -: 16];
          val_nxt       = ring_q[TS_W +: 8];
          ts_nxt        = ring_q[TS_W-1:0];
          pend_nxt      = 1'b0;
          last_nxt      = blast_r;
          state_nxt     = blast_r ? S_IDLE : S_BAT_RD;
        end
      end

      S_PT_RD: begin
        stat_re   = 1'b1;
        state_nxt = S_PT_OUT;
      end

      S_PT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_POINT;
          addr_nxt      = cur_addr_r;
          val_nxt       = stat_q;
          ts_nxt        = 56'd0;
          pend_nxt      = 1'b0;
          last_nxt      = left_r == 6'd1;
          cur_addr_nxt  = cur_addr_r + 16'd1;
          cur_idx_nxt   = cur_idx_r + 1'b1;
          left_nxt      = left_r - 6'd1;
          state_nxt     = (left_r == 6'd1) ? S_IDLE : S_PT_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ws_r        <= '0;
      rs_r        <= '{default: '0};
      cur_rd_r    <= '0;
      bn_r        <= '0;
      blast_r     <= 1'b0;
      left_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ws_r        <= ws_nxt;
      rs_r        <= rs_nxt;
      cur_rd_r    <= cur_rd_nxt;
      bn_r        <= bn_nxt;
      blast_r     <= blast_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_addr_r <= cur_addr_nxt;
    cur_idx_r  <= cur_idx_nxt;
    kind_r     <= kind_nxt;
    addr_r     <= addr_nxt;
    val_r      <= val_nxt;
    ts_r       <= ts_nxt;
    pend_r     <= pend_nxt;
    last_r     <= last_nxt;
  end

  assign clearing            = state_r == S_CLEAR;
  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_info_addr_res   = addr_r;
  assign out_point_value_res = val_r;
  assign out_timestamp_res   = ts_r;
  assign out_pending         = pend_r;
  assign out_last            = last_r;

endmodule

// ===== verif/event_ring_checker.sv =====
// Scoreboard for the multi-reader event ring: watches the input, result and
// configuration channels, predicts every transaction and compares the results.
// Depends on mrer_pkg for the function and result-kind codes.
module event_ring_checker import mrer_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_reader,
  input  logic [15:0] in_info_addr,
  input  logic [7:0]  in_point_value,
  input  logic [55:0] in_timestamp,
  input  logic [5:0]  in_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [15:0] out_info_addr_res,
  input  logic [7:0]  out_point_value_res,
  input  logic [55:0] out_timestamp_res,
  input  logic        out_pending,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_status_base_addr,
  output int          error_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH   = 64;
  localparam int unsigned READER_COUNT = 4;
  localparam int unsigned BATCH_LIMIT  = 8;
  localparam int unsigned POINT_COUNT  = 256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  value;
    logic [55:0] stamp;
    logic        pending;
    logic        last;
  } ring_result_t;

  logic [15:0]  ring_addr   [RING_DEPTH];
  logic [7:0]   ring_value  [RING_DEPTH];
  logic [55:0]  ring_stamp  [RING_DEPTH];
  logic [7:0]   status_mem  [POINT_COUNT];
  int unsigned  head;
  int unsigned  tail        [READER_COUNT];
  logic [15:0]  window_base;
  ring_result_t expected_q  [$];

  initial error_count = 0;

  function automatic int unsigned next_slot(input int unsigned s);
    return (s + 1 >= RING_DEPTH) ? 0 : s + 1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic clear_model();
    int unsigned i;
    for (i = 0; i < RING_DEPTH; i++) begin
      ring_addr[i]  = '0;
      ring_value[i] = '0;
      ring_stamp[i] = '0;
    end
    for (i = 0; i < POINT_COUNT; i++) status_mem[i] = '0;
    for (i = 0; i < READER_COUNT; i++) tail[i] = 0;
    head        = 0;
    window_base = CFG_BASE_RESET;
    expected_q.delete();
  endtask

  task automatic expect_result(input logic [1:0] kind, input logic [15:0] addr,
                               input logic [7:0] value, input logic [55:0] stamp,
                               input logic pending, input logic last);
    ring_result_t r;
    r.kind    = kind;
    r.addr    = addr;
    r.value   = value;
    r.stamp   = stamp;
    r.pending = pending;
    r.last    = last;
    expected_q.push_back(r);
  endtask

  task automatic predict_transaction(input logic [1:0] func, input logic [1:0] reader,
                                     input logic [15:0] addr, input logic [7:0] value,
                                     input logic [55:0] stamp, input logic [5:0] cnt);
    int unsigned lo;
    int unsigned hi;
    int unsigned a;
    int unsigned n;
    int unsigned s;
    int unsigned i;
    lo = window_base;
    hi = lo + POINT_COUNT;
    a  = addr;
    case (func)
      FUNC_WRITE: begin
        if (a >= lo && a < hi) status_mem[a - lo] = value;
        ring_addr[head]  = addr;
        ring_value[head] = value;
        ring_stamp[head] = stamp;
        head = next_slot(head);
        // push any reader caught by the writer past the oldest entry
        for (i = 0; i < READER_COUNT; i++)
          if (tail[i] == head) tail[i] = next_slot(tail[i]);
      end
      FUNC_CHECK: begin
        if (reader >= READER_COUNT) begin
          expect_result(KIND_REJECT, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          expect_result(KIND_PENDING, '0, '0, '0, tail[reader] != head, 1'b1);
        end
      end
      FUNC_BATCH: begin
        if (reader >= READER_COUNT || tail[reader] == head) begin
          expect_result(KIND_REJECT, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          n = (head + RING_DEPTH - tail[reader]) % RING_DEPTH;
          if (n > BATCH_LIMIT) n = BATCH_LIMIT;
          for (i = 0; i < n; i++) begin
            s = tail[reader];
            expect_result(KIND_EVENT, ring_addr[s], ring_value[s], ring_stamp[s], 1'b0,
                          i + 1 == n);
            tail[reader] = next_slot(s);
          end
        end
      end
      FUNC_POINTS: begin
        if (cnt == 0 || cnt > MAX_POINT_RUN || a < lo || a + cnt > hi) begin
          expect_result(KIND_REJECT, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < cnt; i++)
            expect_result(KIND_POINT, 16'(a + i), status_mem[a - lo + i], '0, 1'b0,
                          i + 1 == cnt);
        end
      end
    endcase
  endtask

  task automatic check_result();
    ring_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result with none expected, kind %0d addr %h",
                                out_kind, out_info_addr_res));
      return;
    end
    want = expected_q.pop_front();
    if (out_kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
    if (out_info_addr_res !== want.addr)
      report_mismatch($sformatf("address %h, expected %h", out_info_addr_res, want.addr));
    if (out_point_value_res !== want.value)
      report_mismatch($sformatf("value %h, expected %h", out_point_value_res, want.value));
    if (out_timestamp_res !== want.stamp)
      report_mismatch($sformatf("time tag %h, expected %h", out_timestamp_res, want.stamp));
    if (out_pending !== want.pending)
      report_mismatch($sformatf("pending %b, expected %b", out_pending, want.pending));
    if (out_last !== want.last)
      report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_valid && cfg_ready) window_base = cfg_status_base_addr;
      if (in_valid && !in_stall)
        predict_transaction(in_func, in_reader, in_info_addr, in_point_value,
                            in_timestamp, in_count);
      if (out_valid && !out_stall) check_result();
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== verif/tb.sv =====
// Top-level testbench for multi_reader_event_ring_unit: drives reset, the
// configuration port and the input channel, stalls the result channel.
// Depends on mrer_pkg and event_ring_checker, which predicts and compares.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrer_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [1:0]  in_reader = '0;
  logic [15:0] in_info_addr = '0;
  logic [7:0]  in_point_value = '0;
  logic [55:0] in_timestamp = '0;
  logic [5:0]  in_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_info_addr_res;
  logic [7:0]  out_point_value_res;
  logic [55:0] out_timestamp_res;
  logic        out_pending;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_status_base_addr = '0;

  int error_count;
  int outstanding;
  int idle_cycles = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  multi_reader_event_ring_unit u_dut (.*);

  event_ring_checker u_checker (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // end the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result sink: random stall before each transaction unless in steady mode, two long hold-offs
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    forever begin
      if (taken == 60 || taken == 240) gap = LONG_HOLD;
      else if (rx_steady) gap = 0;
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 32 == 0) rx_steady = ($urandom_range(0, 2) == 0);
    end
  end

  task automatic send_transaction(input logic [1:0] func, input logic [1:0] reader,
                                  input logic [15:0] addr, input logic [7:0] value,
                                  input logic [55:0] stamp, input logic [5:0] cnt);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_func        <= func;
    in_reader      <= reader;
    in_info_addr   <= addr;
    in_point_value <= value;
    in_timestamp   <= stamp;
    in_count       <= cnt;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every expected result is in, then let trailing writes settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_window_base(input logic [15:0] base);
    cfg_status_base_addr <= base;
    cfg_valid            <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_write(input logic [15:0] base);
    int span;
    logic [63:0] wide;
    logic [15:0] a;
    span = 65535 - base;
    if (span > 260) span = 260;
    wide = {$urandom, $urandom};
    a = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'(base + $urandom_range(0, span));
    send_transaction(FUNC_WRITE, 2'($urandom), a, 8'($urandom), wide[55:0], 6'($urandom));
  endtask

  task automatic random_transaction(input logic [15:0] base);
    int pick;
    int c;
    int span;
    logic [1:0] rdr;
    logic [63:0] wide;
    logic [15:0] a;
    logic [5:0] cnt;
    pick = $urandom_range(0, 99);
    // reader 3 is rarely read so the writer laps it
    rdr = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    wide = {$urandom, $urandom};
    if (pick < 45) begin
      random_write(base);
    end else if (pick < 60) begin
      send_transaction(FUNC_CHECK, rdr, 16'($urandom), 8'($urandom), wide[55:0],
                       6'($urandom));
    end else if (pick < 82) begin
      send_transaction(FUNC_BATCH, rdr, 16'($urandom), 8'($urandom), wide[55:0],
                       6'($urandom));
    end else begin
      case ($urandom_range(0, 9))
        0:       cnt = 6'd0;
        1:       cnt = 6'($urandom_range(33, 63));
        default: cnt = 6'($urandom_range(1, 32));
      endcase
      c = (cnt >= 1 && cnt <= 32) ? int'(cnt) : 1;
      // reach a little past the window end to hit the boundary
      span = 258 - c;
      if (span > 65535 - base) span = 65535 - base;
      a = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(base + $urandom_range(0, span));
      send_transaction(FUNC_POINTS, rdr, a, 8'($urandom), wide[55:0], cnt);
    end
  endtask

  initial begin : stimulus
    int phase;
    int k;
    logic [15:0] base;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty ring, window limits at the reset base, then a few events
    send_transaction(FUNC_CHECK,  2'd0, 16'd0,   8'd0,   56'd0, 6'd0);
    send_transaction(FUNC_BATCH,  2'd0, 16'd0,   8'd0,   56'd0, 6'd0);
    send_transaction(FUNC_POINTS, 2'd0, 16'd0,   8'd0,   56'd0, 6'd1);
    send_transaction(FUNC_POINTS, 2'd0, 16'd1,   8'd0,   56'd0, 6'd32);
    send_transaction(FUNC_POINTS, 2'd0, 16'd1,   8'd0,   56'd0, 6'd0);
    send_transaction(FUNC_POINTS, 2'd0, 16'd1,   8'd0,   56'd0, 6'd33);
    send_transaction(FUNC_POINTS, 2'd0, 16'd1,   8'd0,   56'd0, 6'd63);
    send_transaction(FUNC_POINTS, 2'd0, 16'd225, 8'd0,   56'd0, 6'd32);
    send_transaction(FUNC_POINTS, 2'd0, 16'd226, 8'd0,   56'd0, 6'd32);
    send_transaction(FUNC_WRITE,  2'd3, 16'd1,   8'hFF, {56{1'b1}}, 6'h3F);
    send_transaction(FUNC_WRITE,  2'd0, 16'd256, 8'h5A, 56'd0, 6'd0);
    send_transaction(FUNC_WRITE,  2'd0, 16'd257, 8'h11, 56'h00_0000_0000_0001, 6'd0);
    send_transaction(FUNC_WRITE,  2'd0, 16'd0,   8'h22, 56'h80_0000_0000_0000, 6'd0);
    send_transaction(FUNC_WRITE,  2'd0, 16'hFFFF, 8'h80, 56'h12_3456_789A_BCDE, 6'd0);
    send_transaction(FUNC_CHECK,  2'd3, 16'd0,   8'd0,   56'd0, 6'd0);
    send_transaction(FUNC_BATCH,  2'd1, 16'd0,   8'd0,   56'd0, 6'd0);
    send_transaction(FUNC_BATCH,  2'd1, 16'd0,   8'd0,   56'd0, 6'd0);
    send_transaction(FUNC_CHECK,  2'd1, 16'd0,   8'd0,   56'd0, 6'd0);
    send_transaction(FUNC_POINTS, 2'd0, 16'd250, 8'd0,   56'd0, 6'd7);
    send_transaction(FUNC_BATCH,  2'd2, 16'd0,   8'd0,   56'd0, 6'd0);

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       base = 16'h0000;
        1:       base = 16'hFFFF;
        2:       base = 16'hFF00;
        3:       base = 16'($urandom);
        default: base = 16'h0001;
      endcase
      wait_drained();
      write_window_base(base);
      // lap every reader so the oldest entries drop
      if (phase == 0) repeat (70) random_write(base);
      for (k = 0; k < 52; k++) begin
        if (k % 16 == 0) tx_steady = ($urandom_range(0, 2) == 0);
        random_transaction(base);
      end
    end

    wait_drained();
    if (error_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mrer_pkg.sv
design/mrer_front.sv
design/mrer_back.sv
design/multi_reader_event_ring_unit.sv
verif/event_ring_checker.sv
verif/tb.sv
